// ----- design/twl_pkg.sv -----
package twl_pkg;

    // Internal signed value: wide enough for any saturated sum (+-(2^60-1))
    localparam int VW = 62;
    typedef logic signed [VW-1:0] val_t;

    // Multiplier: magnitudes split into two halves, four partial products
    localparam int MW = 62;
    localparam int HW = MW / 2;
    localparam int PW = 2 * MW;
    typedef logic [MW-1:0] mag_t;
    typedef logic [PW-1:0] prod_t;

    localparam val_t        LIM       = {2'b00, {60{1'b1}}};
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [47:0] MAX48     = {48{1'b1}};
    localparam logic [5:0]  EXP_KMAX  = 6'd40;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_STEP_GAIN  = 3'd0,
        REG_NOISE_GAIN = 3'd1,
        REG_TIME_STEP  = 3'd2,
        REG_START_X    = 3'd3,
        REG_START_Y    = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_OPER,
        S_MUL,
        S_MFIN,
        S_EXPW,
        S_DONE
    } state_t;

    // Micro operations of the shared unit
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_EXP
    } op_t;

    // Operand and destination locations: temporaries, then specials
    typedef logic [4:0] loc_t;
    localparam int NUM_TEMPS = 16;
    localparam int TEMP_AW   = 4;

    localparam loc_t T0  = 5'd0;
    localparam loc_t T1  = 5'd1;
    localparam loc_t T2  = 5'd2;
    localparam loc_t T3  = 5'd3;
    localparam loc_t T4  = 5'd4;
    localparam loc_t T5  = 5'd5;
    localparam loc_t T6  = 5'd6;
    localparam loc_t T7  = 5'd7;
    localparam loc_t T8  = 5'd8;
    localparam loc_t T9  = 5'd9;
    localparam loc_t T10 = 5'd10;
    localparam loc_t T11 = 5'd11;
    localparam loc_t T12 = 5'd12;
    localparam loc_t T13 = 5'd13;

    localparam loc_t SRC_X    = 5'd16;
    localparam loc_t SRC_Y    = 5'd17;
    localparam loc_t SRC_ONE  = 5'd18;
    localparam loc_t SRC_TEN  = 5'd19;
    localparam loc_t SRC_SIX  = 5'd20;
    localparam loc_t SRC_C08  = 5'd21;
    localparam loc_t SRC_C53  = 5'd22;
    localparam loc_t SRC_C13  = 5'd23;
    localparam loc_t SRC_SG   = 5'd24;
    localparam loc_t SRC_NG   = 5'd25;
    localparam loc_t SRC_NX   = 5'd26;
    localparam loc_t SRC_NY   = 5'd27;
    localparam loc_t SRC_ZERO = 5'd28;

    localparam loc_t DST_NX  = 5'd16;
    localparam loc_t DST_NY  = 5'd17;
    localparam loc_t DST_FSQ = 5'd18;

    typedef struct packed {
        op_t  op;
        loc_t a;
        loc_t b;
        loc_t d;
    } uinstr_t;

    localparam int PROG_LEN = 64;
    localparam int PC_W     = 6;

    function automatic uinstr_t mk(input op_t o, input loc_t a, input loc_t b, input loc_t d);
        uinstr_t w;
        w.op = o;
        w.a  = a;
        w.b  = b;
        w.d  = d;
        return w;
    endfunction

    // Force and update program
    function automatic uinstr_t prog_word(input logic [PC_W-1:0] pc);
        uinstr_t w;
        case (pc)
            6'd0:  w = mk(OP_SUB, SRC_X, SRC_ONE, T0);
            6'd1:  w = mk(OP_ADD, SRC_X, SRC_ONE, T1);
            6'd2:  w = mk(OP_SUB, SRC_Y, SRC_C53, T2);
            6'd3:  w = mk(OP_SUB, SRC_Y, SRC_C13, T3);
            6'd4:  w = mk(OP_MUL, SRC_X, SRC_X, T4);
            6'd5:  w = mk(OP_MUL, T0, T0, T5);
            6'd6:  w = mk(OP_MUL, T1, T1, T6);
            6'd7:  w = mk(OP_MUL, SRC_Y, SRC_Y, T7);
            6'd8:  w = mk(OP_MUL, T2, T2, T8);
            6'd9:  w = mk(OP_MUL, T3, T3, T9);
            // x: well at (1, 0)
            6'd10: w = mk(OP_ADD, T5, T7, T10);
            6'd11: w = mk(OP_EXP, T10, SRC_ZERO, T10);
            6'd12: w = mk(OP_MUL, T0, T10, T10);
            6'd13: w = mk(OP_MUL, SRC_TEN, T10, T10);
            6'd14: w = mk(OP_SUB, SRC_ZERO, T10, T10);
            // x: middle term
            6'd15: w = mk(OP_EXP, T8, SRC_ZERO, T11);
            6'd16: w = mk(OP_MUL, SRC_SIX, T11, T11);
            6'd17: w = mk(OP_EXP, T7, SRC_ZERO, T12);
            6'd18: w = mk(OP_MUL, SRC_TEN, T12, T12);
            6'd19: w = mk(OP_SUB, T12, T11, T11);
            6'd20: w = mk(OP_EXP, T4, SRC_ZERO, T12);
            6'd21: w = mk(OP_MUL, SRC_X, T12, T12);
            6'd22: w = mk(OP_MUL, T12, T11, T12);
            6'd23: w = mk(OP_ADD, T10, T12, T10);
            // x: well at (-1, 0)
            6'd24: w = mk(OP_ADD, T6, T7, T11);
            6'd25: w = mk(OP_EXP, T11, SRC_ZERO, T11);
            6'd26: w = mk(OP_MUL, T1, T11, T11);
            6'd27: w = mk(OP_MUL, SRC_TEN, T11, T11);
            6'd28: w = mk(OP_SUB, T10, T11, T10);
            // x: confining cubic
            6'd29: w = mk(OP_MUL, SRC_C08, SRC_X, T11);
            6'd30: w = mk(OP_MUL, T11, T4, T11);
            6'd31: w = mk(OP_SUB, T10, T11, T10);
            // y: upper well
            6'd32: w = mk(OP_ADD, T4, T8, T11);
            6'd33: w = mk(OP_EXP, T11, SRC_ZERO, T11);
            6'd34: w = mk(OP_MUL, T2, T11, T11);
            6'd35: w = mk(OP_MUL, SRC_SIX, T11, T11);
            6'd36: w = mk(OP_SUB, SRC_ZERO, T11, T11);
            6'd37: w = mk(OP_ADD, T4, T7, T12);
            6'd38: w = mk(OP_EXP, T12, SRC_ZERO, T12);
            6'd39: w = mk(OP_MUL, SRC_Y, T12, T12);
            6'd40: w = mk(OP_MUL, SRC_TEN, T12, T12);
            6'd41: w = mk(OP_ADD, T11, T12, T11);
            // y: side wells
            6'd42: w = mk(OP_EXP, T5, SRC_ZERO, T12);
            6'd43: w = mk(OP_EXP, T6, SRC_ZERO, T13);
            6'd44: w = mk(OP_ADD, T12, T13, T12);
            6'd45: w = mk(OP_EXP, T7, SRC_ZERO, T13);
            6'd46: w = mk(OP_MUL, SRC_Y, T13, T13);
            6'd47: w = mk(OP_MUL, T13, T12, T13);
            6'd48: w = mk(OP_MUL, SRC_TEN, T13, T13);
            6'd49: w = mk(OP_SUB, T11, T13, T11);
            // y: confining cubic
            6'd50: w = mk(OP_MUL, SRC_C08, T9, T12);
            6'd51: w = mk(OP_MUL, T12, T3, T12);
            6'd52: w = mk(OP_SUB, T11, T12, T11);
            // position update
            6'd53: w = mk(OP_MUL, T10, SRC_SG, T12);
            6'd54: w = mk(OP_ADD, SRC_X, T12, T12);
            6'd55: w = mk(OP_MUL, SRC_NG, SRC_NX, T13);
            6'd56: w = mk(OP_ADD, T12, T13, DST_NX);
            6'd57: w = mk(OP_MUL, T11, SRC_SG, T12);
            6'd58: w = mk(OP_ADD, SRC_Y, T12, T12);
            6'd59: w = mk(OP_MUL, SRC_NG, SRC_NY, T13);
            6'd60: w = mk(OP_ADD, T12, T13, DST_NY);
            // squared force
            6'd61: w = mk(OP_MUL, T10, T10, T12);
            6'd62: w = mk(OP_MUL, T11, T11, T13);
            6'd63: w = mk(OP_ADD, T12, T13, DST_FSQ);
            default: w = mk(OP_ADD, SRC_ZERO, SRC_ZERO, T0);
        endcase
        return w;
    endfunction

    // One entry of the 2^-f table, rounded to frac fraction bits
    function automatic logic [63:0] exp_entry(input int unsigned idx,
                                              input int unsigned log2n,
                                              input int unsigned frac);
        logic [63:0] a;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] t;
        logic [63:0] v;
        int          n;
        a   = (64'(idx) * 64'(LN2_Q32)) >> log2n;
        pos = 64'd1 << 32;
        neg = 64'd0;
        t   = 64'd1 << 32;
        for (n = 1; n <= 24; n++)
        begin
            t = ((t * a) >> 32) / 64'(n);
            if (n % 2 == 1)
            begin
                neg = neg + t;
            end
            else
            begin
                pos = pos + t;
            end
        end
        v = pos - neg;
        return (v + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

endpackage

// ----- design/twl_ram.sv -----
module twl_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two words registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/three_well_langevin_step.sv -----
// Channel   Direction  Handshake              Words
// input     in         in_valid / in_stall    op, noise_x, noise_y
// result    out        out_valid / out_stall  pos_x, pos_y, force_sq, elapsed
// config    in         cfg_write_en           cfg_index, cfg_data
//
// A step word runs a 64-instruction program on one shared add/multiply/exp
// unit: a multiply sums four 31x31 partial products in turn, and an exp runs
// through the multiplier before its table lookup. A restart skips the program.
// The input stalls while a word is in flight; a finished word waits in the
// output register, and the input reopens once it is loaded there.
// Reset clears position, time and control and loads the register defaults.
module three_well_langevin_step import twl_pkg::*; #(
    parameter int FRAC_BITS         = 24,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] noise_x,
    input  logic signed [31:0] noise_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [47:0]        force_sq,
    output logic [47:0]        elapsed,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int LOG2N = $clog2(EXP_TABLE_ENTRIES);

    localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
    localparam longint C08_L = ((64'sd8 <<< FRAC_BITS) + 5) / 10;
    localparam longint C53_L = ((64'sd5 <<< FRAC_BITS) + 1) / 3;
    localparam longint C13_L = ((64'sd1 <<< FRAC_BITS) + 1) / 3;

    localparam val_t ONE_V  = val_t'(ONE_L);
    localparam val_t TEN_V  = val_t'(10 * ONE_L);
    localparam val_t SIX_V  = val_t'(6 * ONE_L);
    localparam val_t C08_V  = val_t'(C08_L);
    localparam val_t C53_V  = val_t'(C53_L);
    localparam val_t C13_V  = val_t'(C13_L);
    localparam val_t EXPMAX = val_t'(24 * ONE_L);
    localparam val_t I32MAX = val_t'(64'sd2147483647);
    localparam val_t I32MIN = val_t'(-64'sd2147483648);

    // 2^-f table
    logic [FRAC_BITS:0] tab_rom [EXP_TABLE_ENTRIES];

    for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++)
    begin : g_tab
        localparam logic [63:0] ENTRY = exp_entry(gi, LOG2N, FRAC_BITS);
        assign tab_rom[gi] = ENTRY[FRAC_BITS:0];
    end

    state_t state_reg, state_next;

    logic [30:0]        step_gain_reg;
    logic [30:0]        noise_gain_reg;
    logic [31:0]        time_step_reg;
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;

    logic signed [31:0] cur_x_reg, cur_x_next;
    logic signed [31:0] cur_y_reg, cur_y_next;
    logic [47:0]        time_acc_reg, time_acc_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [47:0]        force_sq_reg, elapsed_reg;

    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               op_reg;
    logic signed [31:0] nx_in_reg, ny_in_reg;
    logic signed [31:0] nx_reg, ny_reg;
    logic [47:0]        fsq_reg;

    mag_t               mag_a_reg, mag_b_reg;
    logic               neg_reg;
    logic               exp_zero_reg;
    prod_t              acc_reg;
    logic [FRAC_BITS:0] tab_q_reg;
    logic [5:0]         k_reg;

    uinstr_t            ins;
    val_t               ram_a, ram_b;
    val_t               opa, opb;
    val_t               alu_sum;
    val_t               alu_val;
    val_t               mul_val;
    val_t               exp_val;
    val_t               wr_val;
    logic               wr_en;
    logic               ram_we;
    logic               load_out;
    logic               advance;
    logic [2*HW-1:0]    pp;
    prod_t              pp_sh;
    logic [63:0]        mul_mag;
    logic [33:0]        exp_t;
    logic [LOG2N-1:0]   exp_idx;
    val_t               u_val;

    // Pick an operand from the temporaries or the special sources
    function automatic val_t pick(input loc_t c, input val_t q,
                                  input logic signed [31:0] x, input logic signed [31:0] y,
                                  input logic [30:0] sg, input logic [30:0] ng,
                                  input logic signed [31:0] nx, input logic signed [31:0] ny);
        val_t r;
        case (c)
            SRC_X:    r = val_t'(x);
            SRC_Y:    r = val_t'(y);
            SRC_ONE:  r = ONE_V;
            SRC_TEN:  r = TEN_V;
            SRC_SIX:  r = SIX_V;
            SRC_C08:  r = C08_V;
            SRC_C53:  r = C53_V;
            SRC_C13:  r = C13_V;
            SRC_SG:   r = val_t'({1'b0, sg});
            SRC_NG:   r = val_t'({1'b0, ng});
            SRC_NX:   r = val_t'(nx);
            SRC_NY:   r = val_t'(ny);
            SRC_ZERO: r = '0;
            default:  r = q;
        endcase
        return r;
    endfunction

    function automatic mag_t mag_of(input val_t v);
        val_t m;
        m = v[VW-1] ? -v : v;
        return mag_t'(m);
    endfunction

    assign ins = prog_word(pc_reg);

    twl_ram #(
        .WIDTH(VW),
        .DEPTH(NUM_TEMPS)
    ) u_temps (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ins.d[TEMP_AW-1:0]),
        .wdata   (wr_val),
        .raddr_a (ins.a[TEMP_AW-1:0]),
        .raddr_b (ins.b[TEMP_AW-1:0]),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Operand select and saturating add
    always_comb
    begin
        opa = pick(ins.a, ram_a, cur_x_reg, cur_y_reg, step_gain_reg, noise_gain_reg,
                   nx_in_reg, ny_in_reg);
        opb = pick(ins.b, ram_b, cur_x_reg, cur_y_reg, step_gain_reg, noise_gain_reg,
                   nx_in_reg, ny_in_reg);
        alu_sum = (ins.op == OP_SUB) ? opa - opb : opa + opb;
        if (alu_sum > LIM)
        begin
            alu_val = LIM;
        end
        else if (alu_sum < -LIM)
        begin
            alu_val = -LIM;
        end
        else
        begin
            alu_val = alu_sum;
        end
        u_val = opa[VW-1] ? '0 : opa;
    end

    // Partial product for the current step
    always_comb
    begin
        case (cnt_reg)
            2'd0:    pp = mag_a_reg[HW-1:0] * mag_b_reg[HW-1:0];
            2'd1:    pp = mag_a_reg[HW-1:0] * mag_b_reg[MW-1:HW];
            2'd2:    pp = mag_a_reg[MW-1:HW] * mag_b_reg[HW-1:0];
            default: pp = mag_a_reg[MW-1:HW] * mag_b_reg[MW-1:HW];
        endcase
        case (cnt_reg)
            2'd0:    pp_sh = prod_t'(pp);
            2'd1:    pp_sh = prod_t'(pp) << HW;
            2'd2:    pp_sh = prod_t'(pp) << HW;
            default: pp_sh = prod_t'(pp) << (2 * HW);
        endcase
    end

    // Finish multiply and exp
    always_comb
    begin
        mul_mag = acc_reg[63:0] >> FRAC_BITS;
        if (|acc_reg[PW-1:64])
        begin
            mul_val = neg_reg ? -LIM : LIM;
        end
        else
        begin
            mul_val = neg_reg ? -val_t'(mul_mag[VW-1:0]) : val_t'(mul_mag[VW-1:0]);
        end
        exp_t   = acc_reg[63:30];
        exp_idx = exp_t[FRAC_BITS-1 -: LOG2N];
        if (exp_zero_reg || k_reg > EXP_KMAX)
        begin
            exp_val = '0;
        end
        else
        begin
            exp_val = val_t'(tab_q_reg >> k_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cnt_next       = cnt_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        time_acc_next  = time_acc_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_val         = alu_val;
        advance        = 1'b0;
        load_out       = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pc_next    = '0;
                    state_next = op ? S_ISSUE : S_DONE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_OPER;
            end
            S_OPER:
            begin
                cnt_next = '0;
                if (ins.op == OP_ADD || ins.op == OP_SUB)
                begin
                    wr_en   = 1'b1;
                    wr_val  = alu_val;
                    advance = 1'b1;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_MFIN;
                end
            end
            S_MFIN:
            begin
                if (ins.op == OP_MUL)
                begin
                    wr_en   = 1'b1;
                    wr_val  = mul_val;
                    advance = 1'b1;
                end
                else
                begin
                    state_next = S_EXPW;
                end
            end
            S_EXPW:
            begin
                wr_en   = 1'b1;
                wr_val  = exp_val;
                advance = 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (op_reg)
                    begin
                        cur_x_next = nx_reg;
                        cur_y_next = ny_reg;
                        if ({1'b0, time_acc_reg} + 49'(time_step_reg) > {1'b0, MAX48})
                        begin
                            time_acc_next = MAX48;
                        end
                        else
                        begin
                            time_acc_next = time_acc_reg + 48'(time_step_reg);
                        end
                    end
                    else
                    begin
                        cur_x_next    = start_x_reg;
                        cur_y_next    = start_y_reg;
                        time_acc_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next instruction or finish
        if (advance)
        begin
            if (pc_reg == PC_W'(PROG_LEN - 1))
            begin
                state_next = S_DONE;
            end
            else
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = S_ISSUE;
            end
        end
    end

    assign ram_we = wr_en && !ins.d[4];

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            time_acc_reg   <= '0;
            step_gain_reg  <= 31'd167772;
            noise_gain_reg <= 31'd2372657;
            time_step_reg  <= 32'd42949673;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            time_acc_reg  <= time_acc_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_STEP_GAIN:  step_gain_reg  <= cfg_data[30:0];
                    REG_NOISE_GAIN: noise_gain_reg <= cfg_data[30:0];
                    REG_TIME_STEP:  time_step_reg  <= cfg_data;
                    REG_START_X:    start_x_reg    <= cfg_data;
                    REG_START_Y:    start_y_reg    <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg    <= op;
            nx_in_reg <= noise_x;
            ny_in_reg <= noise_y;
        end

        // Load the shared multiplier
        if (state_reg == S_OPER)
        begin
            acc_reg <= '0;
            if (ins.op == OP_EXP)
            begin
                mag_a_reg    <= mag_of(u_val);
                mag_b_reg    <= mag_t'(LOG2E_Q30);
                neg_reg      <= 1'b0;
                exp_zero_reg <= (u_val > EXPMAX);
            end
            else
            begin
                mag_a_reg <= mag_of(opa);
                mag_b_reg <= mag_of(opb);
                neg_reg   <= opa[VW-1] != opb[VW-1];
            end
        end

        if (state_reg == S_MUL)
        begin
            acc_reg <= acc_reg + pp_sh;
        end

        // Table lookup and shift count for exp
        if (state_reg == S_MFIN)
        begin
            tab_q_reg <= tab_rom[exp_idx];
            k_reg     <= exp_t[FRAC_BITS+5:FRAC_BITS];
        end

        // Capture final values
        if (wr_en && ins.d == DST_NX)
        begin
            if (wr_val > I32MAX)
            begin
                nx_reg <= 32'sh7FFFFFFF;
            end
            else if (wr_val < I32MIN)
            begin
                nx_reg <= 32'sh80000000;
            end
            else
            begin
                nx_reg <= wr_val[31:0];
            end
        end
        if (wr_en && ins.d == DST_NY)
        begin
            if (wr_val > I32MAX)
            begin
                ny_reg <= 32'sh7FFFFFFF;
            end
            else if (wr_val < I32MIN)
            begin
                ny_reg <= 32'sh80000000;
            end
            else
            begin
                ny_reg <= wr_val[31:0];
            end
        end
        if (wr_en && ins.d == DST_FSQ)
        begin
            fsq_reg <= (wr_val > val_t'({1'b0, MAX48})) ? MAX48 : wr_val[47:0];
        end

        // Hold the result word
        if (load_out)
        begin
            pos_x_reg    <= cur_x_next;
            pos_y_reg    <= cur_y_next;
            force_sq_reg <= op_reg ? fsq_reg : 48'd0;
            elapsed_reg  <= time_acc_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign force_sq  = force_sq_reg;
    assign elapsed   = elapsed_reg;

endmodule

// ----- design/twl_checker.sv -----
module twl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic [47:0]        force_sq,
    input logic [47:0]        elapsed
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y)
                                   && $stable(force_sq) && $stable(elapsed))
        else $error("stalled result word changed");

    // Close the input once a word is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a word was taken");

    // A new result only comes out of work in flight
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no word in flight");

endmodule

bind three_well_langevin_step twl_checker u_twl_checker (.*);

// ----- tb/tb.sv -----
module tb import twl_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [63:0] fx_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [47:0] force_sq;
        logic [47:0] elapsed;
    } langevin_res_t;

    typedef struct {
        logic        op;
        logic [31:0] noise_x;
        logic [31:0] noise_y;
        bit          typed;
        logic [31:0] want_x;
        logic [31:0] want_y;
    } drive_row_t;

    localparam int  FRAC       = 24;
    localparam int  TAB_N      = 256;
    localparam fx_t SUM_LIM    = (64'sd1 <<< 60) - 1;
    localparam fx_t ONE_Q      = 64'sd1 <<< FRAC;
    localparam int  WDOG_LIMIT = 20000;
    localparam int  DRAIN_CYC  = 20;
    localparam int  HOLD_CYC   = 1500;
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic signed [31:0] noise_x;
    logic signed [31:0] noise_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [47:0]        force_sq;
    logic [47:0]        elapsed;
    logic               cfg_write_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Predictor state and register copies
    logic [63:0]   pow2_tab [TAB_N];
    logic [30:0]   m_step_gain;
    logic [30:0]   m_noise_gain;
    logic [31:0]   m_time_step;
    logic [31:0]   m_start_x;
    logic [31:0]   m_start_y;
    fx_t           m_x;
    fx_t           m_y;
    logic [63:0]   m_time;
    langevin_res_t pending_pos[$];

    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_req;
    int  hold_seen;
    int  hold_left;
    int  quiet_cycles;

    three_well_langevin_step u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .noise_x      (noise_x),
        .noise_y      (noise_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .force_sq     (force_sq),
        .elapsed      (elapsed),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Fixed point helpers of the force computation
    function automatic fx_t sat_add(fx_t a, fx_t b);
        fx_t s;
        s = a + b;
        if (s > SUM_LIM)
        begin
            return SUM_LIM;
        end
        if (s < -SUM_LIM)
        begin
            return -SUM_LIM;
        end
        return s;
    endfunction

    function automatic fx_t q_mul(fx_t a, fx_t b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  q;
        ua = a[63] ? 64'(-a) : 64'(a);
        ub = b[63] ? 64'(-b) : 64'(b);
        p  = {64'd0, ua} * {64'd0, ub};
        if (p[127:64] != 64'd0)
        begin
            q = 64'(SUM_LIM);
        end
        else
        begin
            q = p[63:0] >> FRAC;
            if (q > 64'(SUM_LIM))
            begin
                q = 64'(SUM_LIM);
            end
        end
        return (a[63] ^ b[63]) ? -fx_t'(q) : fx_t'(q);
    endfunction

    function automatic fx_t exp_neg(fx_t u);
        logic [63:0] t;
        logic [63:0] k;
        logic [63:0] idx;
        if (u < 0)
        begin
            u = 0;
        end
        if (u > (64'sd24 <<< FRAC))
        begin
            return 0;
        end
        t   = (64'(u) * 64'd1549082005) >> 30;
        k   = t >> FRAC;
        idx = ((t & ((64'd1 << FRAC) - 1)) * TAB_N) >> FRAC;
        if (idx >= TAB_N)
        begin
            idx = TAB_N - 1;
        end
        if (k > 40)
        begin
            return 0;
        end
        return fx_t'(pow2_tab[idx] >> k);
    endfunction

    function automatic fx_t q_const(int num, int den);
        return ((fx_t'(num) <<< FRAC) + den / 2) / den;
    endfunction

    function automatic fx_t clamp32(fx_t v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Force of the three-well potential at (x, y)
    task automatic three_well_force(input fx_t x, input fx_t y, output fx_t fx, output fx_t fy);
        fx_t ten;
        fx_t six;
        fx_t c08;
        fx_t xm;
        fx_t xp;
        fx_t ym;
        fx_t yu;
        fx_t x2;
        fx_t xm1;
        fx_t xp1;
        fx_t y2;
        fx_t yc;
        fx_t yuu;
        fx_t ea;
        fx_t ex2;
        fx_t eyc;
        fx_t ey2;
        fx_t eb;
        fx_t ec;
        fx_t ed;
        fx_t exm1;
        fx_t exp1;
        fx_t s;
        fx_t mid;
        ten  = q_const(10, 1);
        six  = q_const(6, 1);
        c08  = q_const(8, 10);
        xm   = x - ONE_Q;
        xp   = x + ONE_Q;
        ym   = y - q_const(5, 3);
        yu   = y - q_const(1, 3);
        x2   = q_mul(x, x);
        xm1  = q_mul(xm, xm);
        xp1  = q_mul(xp, xp);
        y2   = q_mul(y, y);
        yc   = q_mul(ym, ym);
        yuu  = q_mul(yu, yu);
        ea   = exp_neg(sat_add(xm1, y2));
        ex2  = exp_neg(x2);
        eyc  = exp_neg(yc);
        ey2  = exp_neg(y2);
        eb   = exp_neg(sat_add(xp1, y2));
        ec   = exp_neg(sat_add(x2, yc));
        ed   = exp_neg(sat_add(x2, y2));
        exm1 = exp_neg(xm1);
        exp1 = exp_neg(xp1);

        s   = -q_mul(ten, q_mul(xm, ea));
        mid = sat_add(-q_mul(six, eyc), q_mul(ten, ey2));
        s   = sat_add(s, q_mul(q_mul(x, ex2), mid));
        s   = sat_add(s, -q_mul(ten, q_mul(xp, eb)));
        s   = sat_add(s, -q_mul(q_mul(c08, x), x2));
        fx  = s;

        s   = -q_mul(six, q_mul(ym, ec));
        s   = sat_add(s, q_mul(ten, q_mul(y, ed)));
        s   = sat_add(s, -q_mul(ten, q_mul(q_mul(y, ey2), sat_add(exm1, exp1))));
        s   = sat_add(s, -q_mul(q_mul(c08, yuu), yu));
        fy  = s;
    endtask

    // Advance the predicted walker by one word
    task automatic langevin_predict(input logic o, input logic [31:0] nx, input logic [31:0] ny,
                                    output langevin_res_t r);
        fx_t         fx;
        fx_t         fy;
        fx_t         sq;
        logic [63:0] fsq;
        fsq = 0;
        if (o == OP_RESTART)
        begin
            m_x    = fx_t'($signed(m_start_x));
            m_y    = fx_t'($signed(m_start_y));
            m_time = 0;
        end
        else
        begin
            three_well_force(m_x, m_y, fx, fy);
            m_x = clamp32(sat_add(sat_add(m_x, q_mul(fx, fx_t'(m_step_gain))),
                                  q_mul(fx_t'(m_noise_gain), fx_t'($signed(nx)))));
            m_y = clamp32(sat_add(sat_add(m_y, q_mul(fy, fx_t'(m_step_gain))),
                                  q_mul(fx_t'(m_noise_gain), fx_t'($signed(ny)))));
            sq  = sat_add(q_mul(fx, fx), q_mul(fy, fy));
            fsq = (64'(sq) > 64'(MAX48)) ? 64'(MAX48) : 64'(sq);
            m_time = m_time + m_time_step;
            if (m_time > 64'(MAX48))
            begin
                m_time = 64'(MAX48);
            end
        end
        r.pos_x    = m_x[31:0];
        r.pos_y    = m_y[31:0];
        r.force_sq = fsq[47:0];
        r.elapsed  = m_time[47:0];
    endtask

    // Offer one word, wait for it to be taken, queue its expected result
    task automatic send_word(input drive_row_t w);
        langevin_res_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= w.op;
        noise_x  <= w.noise_x;
        noise_y  <= w.noise_y;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        langevin_predict(w.op, w.noise_x, w.noise_y, r);
        if (w.typed)
        begin
            r.pos_x    = w.want_x;
            r.pos_y    = w.want_y;
            r.force_sq = '0;
            r.elapsed  = '0;
        end
        pending_pos.push_back(r);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            REG_STEP_GAIN:  m_step_gain  = val[30:0];
            REG_NOISE_GAIN: m_noise_gain = val[30:0];
            REG_TIME_STEP:  m_time_step  = val;
            REG_START_X:    m_start_x    = val;
            REG_START_Y:    m_start_y    = val;
            default: ;
        endcase
    endtask

    // Drain the block, then load a full register set
    task automatic load_settings(input logic [31:0] sg, input logic [31:0] ng,
                                 input logic [31:0] ts, input logic [31:0] sx,
                                 input logic [31:0] sy);
        in_valid <= 1'b0;
        while (pending_pos.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYC) @(posedge clk);
        write_reg(REG_STEP_GAIN, sg);
        write_reg(REG_NOISE_GAIN, ng);
        write_reg(REG_TIME_STEP, ts);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 84000000)) - 42000000);
    endfunction

    function automatic logic [31:0] pick_noise();
        if ($urandom_range(9) == 0)
        begin
            return $urandom;
        end
        return 32'($signed($urandom_range(0, 67108864)) - 33554432);
    endfunction

    // Walker from a restart, with occasional restarts mid-run
    task automatic random_walk(input int n);
        drive_row_t w;
        w.typed = 1'b0;
        w.op    = OP_RESTART;
        w.noise_x = $urandom;
        w.noise_y = $urandom;
        send_word(w);
        repeat (n)
        begin
            w.op      = ($urandom_range(99) < 8) ? OP_RESTART : OP_STEP;
            w.noise_x = pick_noise();
            w.noise_y = pick_noise();
            send_word(w);
        end
    endtask

    // Result checking and receiver stalls
    always @(posedge clk)
    begin
        langevin_res_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_pos.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h", $time, pos_x, pos_y);
                errors++;
            end
            else
            begin
                e = pending_pos.pop_front();
                if (pos_x !== e.pos_x)
                begin
                    $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, pos_x);
                    errors++;
                end
                if (pos_y !== e.pos_y)
                begin
                    $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, pos_y);
                    errors++;
                end
                if (force_sq !== e.force_sq)
                begin
                    $display("%0t: force_sq expected %h actual %h", $time, e.force_sq,
                             force_sq);
                    errors++;
                end
                if (elapsed !== e.elapsed)
                begin
                    $display("%0t: elapsed expected %h actual %h", $time, e.elapsed, elapsed);
                    errors++;
                end
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        drive_row_t  rows[$];
        drive_row_t  w;
        logic [63:0] a;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] t;
        int          i;
        int          n;

        // Build the 2^-f table
        for (i = 0; i < TAB_N; i++)
        begin
            a   = (64'(i) * 64'd2977044472) / TAB_N;
            pos = 64'd1 << 32;
            neg = 0;
            t   = 64'd1 << 32;
            for (n = 1; n <= 24; n++)
            begin
                t = ((t * a) >> 32) / 64'(n);
                if (n % 2 == 1)
                begin
                    neg += t;
                end
                else
                begin
                    pos += t;
                end
            end
            pow2_tab[i] = ((pos - neg) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        end

        errors        = 0;
        hold_req      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        send_idle_pct = 32;
        recv_idle_pct = 87;
        m_step_gain   = 31'd167772;
        m_noise_gain  = 31'd2372657;
        m_time_step   = 32'd42949673;
        m_start_x     = 0;
        m_start_y     = 0;
        m_x           = 0;
        m_y           = 0;
        m_time        = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_RESTART;
        noise_x       = 0;
        noise_y       = 0;
        out_stall     = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = REG_STEP_GAIN;
        cfg_data      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: restarts, zero and extreme noise
        rows = '{
            '{OP_RESTART, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
            '{OP_STEP, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
            '{OP_STEP, 32'h7fffffff, 32'h80000000, 1'b0, 32'h0, 32'h0},
            '{OP_STEP, 32'h80000000, 32'h7fffffff, 1'b0, 32'h0, 32'h0},
            '{OP_STEP, 32'hffffffff, 32'h00000001, 1'b0, 32'h0, 32'h0},
            '{OP_RESTART, 32'hffffffff, 32'hffffffff, 1'b1, 32'h0, 32'h0},
            '{OP_STEP, 32'h01000000, 32'hff000000, 1'b0, 32'h0, 32'h0},
            '{OP_STEP, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0, 32'h0},
            '{OP_STEP, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
            '{OP_RESTART, 32'h12345678, 32'h9abcdef0, 1'b1, 32'h0, 32'h0}
        };
        foreach (rows[k])
        begin
            send_word(rows[k]);
        end

        // Extreme starts: far from the wells, huge cubic terms, zero and then full gains
        load_settings(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000);
        w = '{OP_RESTART, 32'h0, 32'h0, 1'b1, 32'h7fffffff, 32'h80000000};
        send_word(w);
        w = '{OP_STEP, 32'h7fffffff, 32'h7fffffff, 1'b0, 32'h0, 32'h0};
        send_word(w);
        load_settings(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff);
        w = '{OP_RESTART, 32'h0, 32'h0, 1'b1, 32'h80000000, 32'h7fffffff};
        send_word(w);
        w = '{OP_STEP, 32'h80000000, 32'h80000000, 1'b0, 32'h0, 32'h0};
        send_word(w);
        w = '{OP_STEP, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0};
        send_word(w);

        // Random walks over a range of settings and idling modes
        for (i = 0; i < 8; i++)
        begin
            if (i == 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 32;
            end
            if (i == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (i)
                0: load_settings(32'd167772, 32'd2372657, 32'd42949673, 32'h0, 32'h0);
                1: load_settings(32'h0, 32'h0, 32'h0, near_coord(), near_coord());
                2: load_settings(32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                                 near_coord(), near_coord());
                7: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
                default: load_settings($urandom_range(0, 32'h00400000),
                                       $urandom_range(0, 32'h01000000), $urandom,
                                       near_coord(), near_coord());
            endcase
            if (i == 4)
            begin
                hold_req++;
            end
            random_walk(100);
        end

        in_valid <= 1'b0;
        while (pending_pos.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
